@@ hdl/baro_sensor_compensation_assert.svh @@
// ----------------------------------------------------------------------------
// baro sensor compensation assertion macros
// shared property templates, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define BSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// types, codes and helpers shared by the baro compensation block
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned CfgW = 48;

  // configuration register indexes
  localparam logic [1:0] CFG_TEMP       = 2'd0;
  localparam logic [1:0] CFG_PRESS_LOW  = 2'd1;
  localparam logic [1:0] CFG_PRESS_MID  = 2'd2;
  localparam logic [1:0] CFG_PRESS_HIGH = 2'd3;

  localparam logic [19:0] RAW_SKIP = 20'h80000;

  typedef enum logic [4:0] {
    S_IDLE, S_T1, S_T2, S_T3,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
    S_DIV, S_P8, S_P9, S_P10, S_FIN, S_DONE
  } bsc_state_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] n;
    logic signed [63:0] d;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] q;
  } div_rsp_t;

  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    return $signed({{48{v[15]}}, v});
  endfunction

endpackage

@@ hdl/baro_sensor_compensation.sv @@
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// integer temperature and pressure compensation of one raw sample pair
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | in_temp_adc, in_press_adc
//   out     | output    | out_valid / out_stall | temp_centi/valid, press_q24_8/valid
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// a word with both samples valid passes, after acceptance, through thirteen products
// on the shared multiplier, a divide, a saturation step and the load of the result register.
// a temperature-only word runs the first three products; a pressure-only word on the
// stored fine temperature runs the rest; with neither valid the word goes straight to
// the result. in_stall drops in the cycle after the result load, so the next word can
// be taken from then on; a result held by out_stall keeps the
// sequencer in its last state. reset is synchronous and clears coefficients,
// fine temperature and control.
// ----------------------------------------------------------------------------
module baro_sensor_compensation (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [bsc_pkg::CfgW-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [19:0]               in_temp_adc,
  input  logic [19:0]               in_press_adc,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [15:0]        out_temp_centi,
  output logic                      out_temp_valid,
  output logic [31:0]               out_press_q24_8,
  output logic                      out_press_valid
);
  import bsc_pkg::*;

  bsc_state_t state_r, state_nxt;

  logic [CfgW-1:0] tc_r, pl_r, pm_r, ph_r;
  logic signed [31:0] fine_r;
  logic [19:0] rt_r, rp_r;
  logic tv_r, pok_r, issued_r, issued_nxt;
  logic signed [63:0] x_r, y_r, sq_r, v2_r, num_r, p_r;
  logic signed [15:0] temp_r;
  logic [31:0] press_r;
  logic out_valid_r;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  logic in_acc, tv_in, pv_in, mul_st, div_st, go, out_load;
  logic signed [63:0] a_t, b_t, v1p, pdiff, ps, f_new, fin_sum;
  logic signed [35:0] f5;
  logic signed [27:0] tcw;

  bsc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  bsc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign tv_in    = (in_temp_adc != 20'd0) && (in_temp_adc != RAW_SKIP);
  assign pv_in    = (in_press_adc != 20'd0) && (in_press_adc != RAW_SKIP);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign mul_st = state_r inside {S_T1, S_T2, S_T3, S_P1, S_P2, S_P3, S_P4, S_P5,
                                  S_P6, S_P7, S_P8, S_P9, S_P10};
  assign div_st = (state_r == S_DIV);
  assign go     = (mul_st || div_st) && !issued_r;

  // datapath terms
  assign a_t   = $signed({47'd0, rt_r[19:3]}) - $signed({47'd0, tc_r[15:0], 1'b0});
  assign b_t   = $signed({48'd0, rt_r[19:4]}) - $signed({48'd0, tc_r[15:0]});
  assign v1p   = $signed({{32{fine_r[31]}}, fine_r}) - 64'sd128000;
  assign pdiff = 64'sd1048576 - $signed({44'd0, rp_r});
  assign ps    = p_r >>> 13;
  assign f_new = (x_r >>> 11) + (mrsp.res >>> 14);
  assign f5    = ($signed(f_new[35:0]) <<< 2) + $signed(f_new[35:0]) + 36'sd128;
  assign tcw   = 28'(f5 >>> 8);
  assign fin_sum = ((p_r + v2_r + x_r) >>> 8) + (sx16(ph_r[15:0]) <<< 4);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (tv_in) state_nxt = S_T1;
          else if (pv_in && fine_r != 32'sd0) state_nxt = S_P1;
          else state_nxt = S_DONE;
        end
      end
      S_T1:  if (mrsp.done) state_nxt = S_T2;
      S_T2:  if (mrsp.done) state_nxt = S_T3;
      S_T3: begin
        if (mrsp.done) state_nxt = (pok_r && f_new[31:0] != 32'd0) ? S_P1 : S_DONE;
      end
      S_P1:  if (mrsp.done) state_nxt = S_P2;
      S_P2:  if (mrsp.done) state_nxt = S_P3;
      S_P3:  if (mrsp.done) state_nxt = S_P4;
      S_P4:  if (mrsp.done) state_nxt = S_P5;
      S_P5:  if (mrsp.done) state_nxt = S_P6;
      S_P6: begin
        if (mrsp.done) state_nxt = ((mrsp.res >>> 33) == 64'sd0) ? S_DONE : S_P7;
      end
      S_P7:  if (mrsp.done) state_nxt = S_DIV;
      S_DIV: if (drsp.done) state_nxt = S_P8;
      S_P8:  if (mrsp.done) state_nxt = S_P9;
      S_P9:  if (mrsp.done) state_nxt = S_P10;
      S_P10: if (mrsp.done) state_nxt = S_FIN;
      S_FIN: state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // unit requests and operand selection
  always_comb begin
    mreq.start = go && mul_st;
    mreq.a     = 64'sd0;
    mreq.b     = 64'sd0;
    dreq.start = go && div_st;
    dreq.n     = num_r;
    dreq.d     = x_r;
    issued_nxt = (mul_st || div_st) ? ((issued_r || go) && !mrsp.done && !drsp.done)
                                    : 1'b0;
    case (state_r)
      S_T1:  begin mreq.a = a_t;          mreq.b = sx16(tc_r[31:16]); end
      S_T2:  begin mreq.a = b_t;          mreq.b = b_t;               end
      S_T3:  begin mreq.a = y_r >>> 12;   mreq.b = sx16(tc_r[47:32]); end
      S_P1:  begin mreq.a = v1p;          mreq.b = v1p;               end
      S_P2:  begin mreq.a = sq_r;         mreq.b = sx16(pm_r[47:32]); end
      S_P3:  begin mreq.a = v1p;          mreq.b = sx16(pm_r[31:16]); end
      S_P4:  begin mreq.a = sq_r;         mreq.b = sx16(pl_r[47:32]); end
      S_P5:  begin mreq.a = v1p;          mreq.b = sx16(pl_r[31:16]); end
      S_P6:  begin
        mreq.a = x_r + 64'sd140737488355328;
        mreq.b = $signed({48'd0, pl_r[15:0]});
      end
      S_P7:  begin mreq.a = (pdiff <<< 31) - v2_r; mreq.b = 64'sd3125; end
      S_P8:  begin mreq.a = sx16(ph_r[47:32]); mreq.b = ps;         end
      S_P9:  begin mreq.a = y_r;          mreq.b = ps;                end
      S_P10: begin mreq.a = sx16(ph_r[31:16]); mreq.b = p_r;        end
      default: begin mreq.a = 64'sd0;     mreq.b = 64'sd0;            end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      fine_r      <= 32'sd0;
      tc_r        <= '0;
      pl_r        <= '0;
      pm_r        <= '0;
      ph_r        <= '0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == S_T3 && mrsp.done) fine_r <= $signed(f_new[31:0]);
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEMP:       tc_r <= cfg_data;
          CFG_PRESS_LOW:  pl_r <= cfg_data;
          CFG_PRESS_MID:  pm_r <= cfg_data;
          CFG_PRESS_HIGH: ph_r <= cfg_data;
          default:        tc_r <= tc_r;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rt_r  <= in_temp_adc;
      rp_r  <= in_press_adc;
      tv_r  <= tv_in;
      pok_r <= pv_in && (tv_in || fine_r != 32'sd0);
    end
    if (mrsp.done) begin
      case (state_r)
        S_T1:  x_r  <= mrsp.res;
        S_T2:  y_r  <= mrsp.res;
        S_T3: begin
          if (tcw > 28'sd32767) temp_r <= 16'sh7fff;
          else if (tcw < -28'sd32768) temp_r <= 16'sh8000;
          else temp_r <= tcw[15:0];
          if (f_new[31:0] == 32'd0) pok_r <= 1'b0;
        end
        S_P1:  sq_r <= mrsp.res;
        S_P2:  v2_r <= mrsp.res;
        S_P3:  v2_r <= v2_r + (mrsp.res <<< 17) + (sx16(pm_r[15:0]) <<< 35);
        S_P4:  x_r  <= mrsp.res >>> 8;
        S_P5:  x_r  <= x_r + (mrsp.res <<< 12);
        S_P6: begin
          x_r <= mrsp.res >>> 33;
          if ((mrsp.res >>> 33) == 64'sd0) pok_r <= 1'b0;
        end
        S_P7:  num_r <= mrsp.res;
        S_P8:  y_r  <= mrsp.res;
        S_P9:  v2_r <= mrsp.res >>> 25;
        S_P10: x_r  <= mrsp.res >>> 19;
        default: x_r <= x_r;
      endcase
    end
    if (drsp.done) p_r <= drsp.q;
    if (state_r == S_FIN) begin
      if (fin_sum < 64'sd0) press_r <= 32'd0;
      else if (fin_sum[63:32] != 32'd0) press_r <= 32'hffffffff;
      else press_r <= fin_sum[31:0];
    end
    if (out_load) begin
      out_temp_centi  <= tv_r ? temp_r : 16'sd0;
      out_temp_valid  <= tv_r;
      out_press_q24_8 <= pok_r ? press_r : 32'd0;
      out_press_valid <= pok_r;
    end
  end

  assign out_valid = out_valid_r;

  `include "baro_sensor_compensation_assert.svh"

  `BSC_ASSERT_IMP(a_units_excl, 1'b1, !(mrsp.busy && drsp.busy), "mul and div both busy")
  `BSC_ASSERT_NXT(a_load_from_done, out_load, out_valid, "result load lost")
  `BSC_ASSERT_IMP(a_press_zero, out_valid && !out_press_valid, out_press_q24_8 == 32'd0,
                  "invalid pressure not zero")
  `BSC_ASSERT_IMP(a_temp_zero, out_valid && !out_temp_valid, out_temp_centi == 16'sd0,
                  "invalid temperature not zero")

endmodule

@@ hdl/bsc_mul.sv @@
// ----------------------------------------------------------------------------
// bsc_mul
// 64x64 wrapping multiplier built from one 32x32 multiplier, one partial product at a time
// ----------------------------------------------------------------------------
module bsc_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  bsc_pkg::mul_req_t req,
  output bsc_pkg::mul_rsp_t rsp
);
  import bsc_pkg::*;

  logic        busy_r, done_r;
  logic [1:0]  cnt_r;
  logic [63:0] a_r, b_r, acc_r, prod_r;
  logic [31:0] op_a, op_b;

  // only the low 32 bits of the cross products reach the result
  always_comb begin
    case (cnt_r)
      2'd0:    begin op_a = a_r[31:0];  op_b = b_r[31:0];  end
      2'd1:    begin op_a = a_r[31:0];  op_b = b_r[63:32]; end
      default: begin op_a = a_r[63:32]; op_b = b_r[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end else if (busy_r) begin
      if (cnt_r != 2'd3) prod_r <= op_a * op_b;
      if (cnt_r == 2'd1) acc_r <= prod_r;
      else if (cnt_r != 2'd0) acc_r <= acc_r + {prod_r[31:0], 32'd0};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = $signed(acc_r);

endmodule

@@ hdl/bsc_div.sv @@
// ----------------------------------------------------------------------------
// bsc_div
// signed 64-bit divider, truncating, one restoring step per cycle
// ----------------------------------------------------------------------------
module bsc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bsc_pkg::div_req_t req,
  output bsc_pkg::div_rsp_t rsp
);
  import bsc_pkg::*;

  logic        busy_r, done_r, neg_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r, quo_r, den_r;
  logic [64:0] trial;
  logic [63:0] un, ud;

  assign un    = req.n[63] ? 64'(-req.n) : req.n;
  assign ud    = req.d[63] ? 64'(-req.d) : req.d;
  assign trial = {rem_r, quo_r[63]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= 64'd0;
      quo_r <= un;
      den_r <= ud;
      neg_r <= req.n[63] ^ req.d[63];
    end else if (busy_r) begin
      rem_r <= trial[64] ? {rem_r[62:0], quo_r[63]} : trial[63:0];
      quo_r <= {quo_r[62:0], ~trial[64]};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.q    = neg_r ? $signed(64'(-quo_r)) : $signed(quo_r);

endmodule

@@ tb/tb_baro_sensor_compensation.sv @@
// ----------------------------------------------------------------------------
// tb_baro_sensor_compensation
// checks temperature and pressure compensation against an in-bench predictor:
// coefficient sets from typical to extreme, invalid and skipped raw samples,
// zero fine temperature and zero divisor, random traffic with random stalls
// ----------------------------------------------------------------------------
module tb_baro_sensor_compensation;
  import bsc_pkg::*;

  typedef struct {
    logic signed [15:0] temp_centi;
    logic               temp_valid;
    logic [31:0]        press_q24_8;
    logic               press_valid;
  } comp_word_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [47:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [19:0]        in_temp_adc;
  logic [19:0]        in_press_adc;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_temp_centi;
  logic               out_temp_valid;
  logic [31:0]        out_press_q24_8;
  logic               out_press_valid;

  // predictor copy of the registers and fine temperature
  logic [47:0] coef_temp, coef_plo, coef_pmid, coef_phi;
  int          fine_pred;
  comp_word_t  pending_q[$];
  int          err_cnt;
  bit          idle_en;

  baro_sensor_compensation dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_temp_adc(in_temp_adc), .in_press_adc(in_press_adc),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_temp_centi(out_temp_centi), .out_temp_valid(out_temp_valid),
    .out_press_q24_8(out_press_q24_8), .out_press_valid(out_press_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint sext16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  // truncating divide, most negative by -1 wraps
  function automatic longint trunc_div(longint n, longint d);
    longint unsigned un, ud, q;
    un = n < 0 ? 64'd0 - n : n;
    ud = d < 0 ? 64'd0 - d : d;
    q = un / ud;
    return ((n < 0) != (d < 0)) ? longint'(64'd0 - q) : longint'(q);
  endfunction

  function automatic comp_word_t compensate(logic [19:0] rt, logic [19:0] rp);
    comp_word_t r;
    longint rtl, a, b, f, tc;
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint v1, v2, sq, p, ps, w1, w2;
    bit tv, pv;
    tv = rt != 20'd0 && rt != RAW_SKIP;
    pv = rp != 20'd0 && rp != RAW_SKIP;
    tc = 0;
    r.press_q24_8 = '0;
    if (tv) begin
      rtl = rt;
      a = (rtl >>> 3) - 2 * longint'(coef_temp[15:0]);
      b = (rtl >>> 4) - longint'(coef_temp[15:0]);
      f = ((a * sext16(coef_temp[31:16])) >>> 11) +
          ((((b * b) >>> 12) * sext16(coef_temp[47:32])) >>> 14);
      fine_pred = int'(f);
      tc = (f * 5 + 128) >>> 8;
      if (tc > 32767) tc = 32767;
      if (tc < -32768) tc = -32768;
    end
    if (fine_pred == 0) pv = 1'b0;
    if (pv) begin
      p1 = longint'(coef_plo[15:0]);
      p2 = sext16(coef_plo[31:16]);  p3 = sext16(coef_plo[47:32]);
      p4 = sext16(coef_pmid[15:0]);  p5 = sext16(coef_pmid[31:16]);
      p6 = sext16(coef_pmid[47:32]);
      p7 = sext16(coef_phi[15:0]);   p8 = sext16(coef_phi[31:16]);
      p9 = sext16(coef_phi[47:32]);
      v1 = longint'(fine_pred) - 128000;
      sq = v1 * v1;
      v2 = sq * p6 + ((v1 * p5) << 17) + (p4 << 35);
      v1 = ((sq * p3) >>> 8) + ((v1 * p2) << 12);
      v1 = (((longint'(1) << 47) + v1) * p1) >>> 33;
      if (v1 == 0) begin
        pv = 1'b0;
      end else begin
        p = 1048576 - longint'(rp);
        p = trunc_div(((p << 31) - v2) * 3125, v1);
        ps = p >>> 13;
        w1 = (p9 * ps * ps) >>> 25;
        w2 = (p8 * p) >>> 19;
        p = ((p + w1 + w2) >>> 8) + (p7 << 4);
        if (p < 0) r.press_q24_8 = '0;
        else if (p > longint'(64'hFFFF_FFFF)) r.press_q24_8 = 32'hFFFF_FFFF;
        else r.press_q24_8 = p[31:0];
      end
    end
    r.temp_centi = tc[15:0];
    r.temp_valid = tv;
    r.press_valid = pv;
    return r;
  endfunction

  task automatic report_err(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk) begin
    comp_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_err("result word with nothing expected");
      end else begin
        exp_w = pending_q.pop_front();
        if (out_temp_centi !== exp_w.temp_centi)
          report_err($sformatf("temp_centi %0d exp %0d", out_temp_centi, exp_w.temp_centi));
        if (out_temp_valid !== exp_w.temp_valid)
          report_err($sformatf("temp_valid %0b exp %0b", out_temp_valid, exp_w.temp_valid));
        if (out_press_q24_8 !== exp_w.press_q24_8)
          report_err($sformatf("press %08h exp %08h", out_press_q24_8, exp_w.press_q24_8));
        if (out_press_valid !== exp_w.press_valid)
          report_err($sformatf("press_valid %0b exp %0b", out_press_valid,
                               exp_w.press_valid));
      end
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_TEMP:      coef_temp = val;
      CFG_PRESS_LOW: coef_plo = val;
      CFG_PRESS_MID: coef_pmid = val;
      default:       coef_phi = val;
    endcase
  endtask

  task automatic load_coeffs(logic [47:0] t, logic [47:0] pl, logic [47:0] pm,
                             logic [47:0] ph);
    write_reg(CFG_TEMP, t);
    write_reg(CFG_PRESS_LOW, pl);
    write_reg(CFG_PRESS_MID, pm);
    write_reg(CFG_PRESS_HIGH, ph);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic [19:0] rt, logic [19:0] rp);
    int n;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid = 1'b1;
    in_temp_adc = rt;
    in_press_adc = rp;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_q.push_back(compensate(rt, rp));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait for every result, then idle before the next test
  task automatic drain;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic logic [19:0] rand_raw();
    case ($urandom_range(0, 15))
      0:       return 20'd0;
      1:       return RAW_SKIP;
      2:       return 20'hFFFFF;
      3:       return 20'($urandom_range(1, 15));
      default: return 20'($urandom_range(0, 20'hFFFFF));
    endcase
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom()), $urandom()};
  endfunction

  localparam logic [47:0] TYP_T  = {-16'sd1000, 16'd26435, 16'd27504};
  localparam logic [47:0] TYP_PL = {16'd3024, -16'sd10685, 16'd36477};
  localparam logic [47:0] TYP_PM = {-16'sd7, 16'd140, 16'd2855};
  localparam logic [47:0] TYP_PH = {16'd6000, -16'sd14600, 16'd15500};

  // zero coefficients: fine temperature stays zero, so pressure is invalid
  task automatic test_after_reset;
    send_word(20'd519888, 20'd415148);
    send_word(20'hFFFFF, 20'hFFFFF);
    drain();
  endtask

  task automatic test_directed;
    load_coeffs(TYP_T, TYP_PL, TYP_PM, TYP_PH);
    send_word(20'd0, 20'd415148);        // fine temperature still zero
    send_word(20'd519888, 20'd415148);
    send_word(20'd0, 20'd415148);        // invalid temp keeps fine temperature
    send_word(RAW_SKIP, 20'd300000);
    send_word(20'd519888, 20'd0);
    send_word(20'd519888, RAW_SKIP);
    send_word(20'hFFFFF, 20'hFFFFF);
    send_word(20'd1, 20'd1);
    send_word(20'h7FFFF, 20'h80001);
    send_word(20'h80001, 20'h7FFFF);
    send_word(20'd440000, 20'd1);
    send_word(20'd600000, 20'hFFFFF);
    drain();
    // zero divisor term
    write_reg(CFG_PRESS_LOW, {TYP_PL[47:16], 16'd0});
    send_word(20'd519888, 20'd415148);
    send_word(20'd0, 20'd1);
    drain();
  endtask

  task automatic test_extreme_coeffs;
    logic [47:0] pats[4];
    pats = '{48'hFFFF_FFFF_FFFF, 48'h8000_8000_FFFF, 48'h7FFF_7FFF_FFFF, 48'h8000_7FFF_0001};
    foreach (pats[k]) begin
      load_coeffs(pats[k], pats[(k + 1) % 4], pats[(k + 2) % 4], pats[(k + 3) % 4]);
      send_word(20'hFFFFF, 20'hFFFFF);
      send_word(20'd1, 20'd1);
      send_word(20'd8, 20'h7FFFF);
      drain();
    end
  endtask

  task automatic test_random(int items, int phases);
    for (int ph = 0; ph < phases; ph++) begin
      if (ph % 2 == 0)
        load_coeffs(TYP_T ^ ($urandom() & 48'h00FF_00FF_0FFF),
                    TYP_PL ^ ($urandom() & 48'h00FF_00FF_0FFF),
                    TYP_PM ^ ($urandom() & 48'h000F_00FF_0FFF),
                    TYP_PH ^ ($urandom() & 48'h00FF_0FFF_0FFF));
      else
        load_coeffs(rand48(), rand48(), rand48(), rand48());
      for (int i = 0; i < items; i++) begin
        if ($urandom_range(0, 3) != 0)
          send_word(20'($urandom_range(400000, 640000)),
                    20'($urandom_range(200000, 700000)));
        else
          send_word(rand_raw(), rand_raw());
      end
      drain();
    end
  endtask

  initial begin
    err_cnt = 0;
    idle_en = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TEMP;
    cfg_data = '0;
    in_valid = 1'b0;
    in_temp_adc = '0;
    in_press_adc = '0;
    coef_temp = '0; coef_plo = '0; coef_pmid = '0; coef_phi = '0;
    fine_pred = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_after_reset();
    test_directed();
    test_extreme_coeffs();
    test_random(200, 8);
    idle_en = 1'b0;
    test_random(100, 2);
    if (err_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/bsc_pkg.sv
hdl/bsc_mul.sv
hdl/bsc_div.sv
hdl/baro_sensor_compensation.sv
tb/tb_baro_sensor_compensation.sv
